// File: design/tmtf_pkg.sv
// Package for the texture memory texel fetch block: beat types and code constants.
// Used by tmtf_out_buf and texture_memory_texel_fetch; depends on nothing else.
`default_nettype none

package tmtf_pkg;

    localparam int MEMORY_BYTES_DEF = 4096;
    localparam int PALETTE_BASE_DEF = 2048;

    localparam logic [1:0] OP_WRITE_BYTE  = 2'd0;
    localparam logic [1:0] OP_WRITE_ENTRY = 2'd1;
    localparam logic [1:0] OP_FETCH       = 2'd2;

    localparam logic [1:0] SIZE_4  = 2'd0;
    localparam logic [1:0] SIZE_8  = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;
    localparam logic [1:0] SIZE_32 = 2'd3;

    localparam logic [2:0] FMT_YUV = 3'd1;
    localparam logic [2:0] FMT_CI  = 3'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] address;
        logic [7:0]  write_byte;
        logic [7:0]  entry_index;
        logic [15:0] entry_color;
        logic [1:0]  texel_size;
        logic [2:0]  texel_format;
        logic        low_nibble;
        logic [3:0]  palette_select;
    } in_t;

    typedef struct packed {
        logic [31:0] texel_bits;
        logic [1:0]  out_size;
        logic [2:0]  out_format;
        logic [7:0]  luma;
        logic [7:0]  chroma_u;
        logic [7:0]  chroma_v;
    } out_t;

endpackage

`default_nettype wire

// File: design/texture_memory_texel_fetch.sv
// Top level of the texture memory with texel fetch and palette lookup.
// Depends on tmtf_pkg and tmtf_out_buf.
//
// Usage: items arrive on in_valid/in_ready/in_data, one beat each. A byte write
// or a palette entry write gives no result; a texel fetch gives one result beat
// on out_valid/out_ready/out_data. The palette format register is written on
// cfg_valid/cfg_ready/cfg_data, which is always ready; write it only while idle.
// The state is one byte-wide synchronous memory with one read and one write port,
// read one byte per cycle, so an item's duration follows the number of bytes read.
// A byte write is stored on accept; a palette entry write stores its high byte
// then and its low byte in ST_PWR. A fetch of n bytes (1, 2, 3 for a yuv texel,
// or 4) runs ST_RD, ST_TAIL, ST_PUSH; a colour-index lookup adds a palette read.
// The result enters the output register at the same edge at which the block
// becomes ready again, so the next item is taken while that result waits. If the
// receiver stalls with the output register full, the block holds the finished
// result and takes no new item until the register frees up.
// After reset the block clears all MEMORY_BYTES bytes of memory, one byte per cycle,
// with in_ready low; configuration writes are taken during that pass.
`default_nettype none

module texture_memory_texel_fetch #(
    parameter int MEMORY_BYTES = tmtf_pkg::MEMORY_BYTES_DEF,
    parameter int PALETTE_BASE = tmtf_pkg::PALETTE_BASE_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tmtf_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output tmtf_pkg::out_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_data
);

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(MEMORY_BYTES - 1);
    localparam logic [19:0] M1 = 20'(MEMORY_BYTES);
    localparam logic [19:0] M2 = 20'(2 * MEMORY_BYTES);
    localparam logic [19:0] M4 = 20'(4 * MEMORY_BYTES);
    localparam logic [12:0] PAL_BASE = 13'(PALETTE_BASE);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PWR,
        ST_RD,
        ST_TAIL,
        ST_PUSH
    } state_t;

    function automatic logic [AW-1:0] wrap(input logic [12:0] x);
        logic [19:0] r;
        r = 20'(x);
        if (r >= M4)
        begin
            r = r - M4;
        end
        if (r >= M2)
        begin
            r = r - M2;
        end
        if (r >= M1)
        begin
            r = r - M1;
        end
        return r[AW-1:0];
    endfunction

    logic [7:0] mem [MEMORY_BYTES];

    state_t         state_reg;
    logic [AW-1:0]  clr_reg;
    logic [2:0]     pf_reg;
    logic [12:0]    a_reg;
    logic [7:0]     wbyte_reg;
    logic [1:0]     idx_reg;
    logic [1:0]     last_reg;
    logic [31:0]    acc_reg;
    logic           yuv_reg;
    logic           nib_reg;
    logic           chain_reg;
    logic           odd_reg;
    logic [3:0]     bank_reg;
    logic [1:0]     size_reg;
    logic [2:0]     fmt_reg;
    tmtf_pkg::out_t res_reg;
    logic [7:0]     mem_q;

    logic           accept;
    logic           we;
    logic [AW-1:0]  wa;
    logic [7:0]     wd;
    logic [12:0]    rd_off;
    logic [AW-1:0]  ra;
    logic [12:0]    entry_addr;
    logic [31:0]    acc_fin;
    logic [3:0]     nibble;
    logic [7:0]     chain_idx;
    logic           push_valid;
    logic           push_ready;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign accept     = in_valid && in_ready;
    assign push_valid = (state_reg == ST_PUSH);
    assign entry_addr = PAL_BASE + {2'b00, in_data.entry_index, 3'b000};
    assign acc_fin    = {acc_reg[23:0], mem_q};
    assign nibble     = odd_reg ? mem_q[3:0] : mem_q[7:4];
    assign chain_idx  = nib_reg ? {bank_reg, nibble} : mem_q;

    always_comb
    begin
        we = 1'b0;
        wa = wrap(a_reg + 13'd1);
        wd = wbyte_reg;
        if (state_reg == ST_CLEAR)
        begin
            we = 1'b1;
            wa = clr_reg;
            wd = 8'h00;
        end
        else if (state_reg == ST_PWR)
        begin
            we = 1'b1;
        end
        else if (accept && in_data.op == tmtf_pkg::OP_WRITE_BYTE)
        begin
            we = 1'b1;
            wa = wrap({1'b0, in_data.address});
            wd = in_data.write_byte;
        end
        else if (accept && in_data.op == tmtf_pkg::OP_WRITE_ENTRY)
        begin
            we = 1'b1;
            wa = wrap(entry_addr);
            wd = in_data.entry_color[15:8];
        end
    end

    always_comb
    begin
        if (yuv_reg)
        begin
            unique case (idx_reg)
                2'd0:    rd_off = a_reg + 13'd1;
                2'd1:    rd_off = {a_reg[12:2], 2'b00};
                default: rd_off = {a_reg[12:2], 2'b10};
            endcase
        end
        else
        begin
            rd_off = a_reg + 13'(idx_reg);
        end
        ra = wrap(rd_off);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        mem_q <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pf_reg    <= 3'd0;
            a_reg     <= '0;
            wbyte_reg <= '0;
            idx_reg   <= '0;
            last_reg  <= '0;
            acc_reg   <= '0;
            yuv_reg   <= 1'b0;
            nib_reg   <= 1'b0;
            chain_reg <= 1'b0;
            odd_reg   <= 1'b0;
            bank_reg  <= '0;
            size_reg  <= '0;
            fmt_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pf_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == LAST_ENTRY)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && in_data.op == tmtf_pkg::OP_WRITE_ENTRY)
                    begin
                        a_reg     <= entry_addr;
                        wbyte_reg <= in_data.entry_color[7:0];
                        state_reg <= ST_PWR;
                    end
                    else if (accept && in_data.op == tmtf_pkg::OP_FETCH)
                    begin
                        a_reg     <= {1'b0, in_data.address};
                        idx_reg   <= 2'd0;
                        acc_reg   <= '0;
                        odd_reg   <= in_data.low_nibble;
                        bank_reg  <= in_data.palette_select;
                        size_reg  <= in_data.texel_size;
                        nib_reg   <= (in_data.texel_size == tmtf_pkg::SIZE_4);
                        unique case (in_data.texel_size)
                            tmtf_pkg::SIZE_4, tmtf_pkg::SIZE_8:
                            begin
                                last_reg  <= 2'd0;
                                fmt_reg   <= in_data.texel_format;
                                yuv_reg   <= 1'b0;
                                chain_reg <= (in_data.texel_format == tmtf_pkg::FMT_CI);
                            end
                            tmtf_pkg::SIZE_16:
                            begin
                                fmt_reg   <= in_data.texel_format;
                                chain_reg <= 1'b0;
                                yuv_reg   <= (in_data.texel_format == tmtf_pkg::FMT_YUV);
                                last_reg  <= (in_data.texel_format == tmtf_pkg::FMT_YUV)
                                             ? 2'd2 : 2'd1;
                            end
                            default:
                            begin
                                last_reg  <= 2'd3;
                                yuv_reg   <= 1'b0;
                                chain_reg <= 1'b0;
                                fmt_reg   <= (in_data.texel_format == tmtf_pkg::FMT_CI)
                                             ? pf_reg : in_data.texel_format;
                            end
                        endcase
                        state_reg <= ST_RD;
                    end
                end
                ST_PWR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_RD:
                begin
                    if (idx_reg != 2'd0)
                    begin
                        acc_reg <= acc_fin;
                    end
                    if (idx_reg == last_reg)
                    begin
                        state_reg <= ST_TAIL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                ST_TAIL:
                begin
                    if (chain_reg)
                    begin
                        a_reg     <= PAL_BASE + {2'b00, chain_idx, 3'b000};
                        idx_reg   <= 2'd0;
                        acc_reg   <= '0;
                        size_reg  <= tmtf_pkg::SIZE_16;
                        fmt_reg   <= pf_reg;
                        yuv_reg   <= (pf_reg == tmtf_pkg::FMT_YUV);
                        last_reg  <= (pf_reg == tmtf_pkg::FMT_YUV) ? 2'd2 : 2'd1;
                        nib_reg   <= 1'b0;
                        chain_reg <= 1'b0;
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        if (yuv_reg)
                        begin
                            res_reg.texel_bits <= '0;
                            res_reg.luma       <= acc_fin[23:16];
                            res_reg.chroma_u   <= acc_fin[15:8];
                            res_reg.chroma_v   <= acc_fin[7:0];
                        end
                        else
                        begin
                            res_reg.texel_bits <= nib_reg ? 32'(nibble) : acc_fin;
                            res_reg.luma       <= '0;
                            res_reg.chroma_u   <= '0;
                            res_reg.chroma_v   <= '0;
                        end
                        res_reg.out_size   <= size_reg;
                        res_reg.out_format <= fmt_reg;
                        state_reg          <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    tmtf_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (res_reg),
        .push_ready (push_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    a_rd_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (idx_reg <= last_reg))
        else $error("read index ran past the last byte of the phase");

    a_fetch_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.op == tmtf_pkg::OP_FETCH) |=> (state_reg == ST_RD))
        else $error("accepted fetch did not start reading");

    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> (push_valid && $stable(res_reg)))
        else $error("finished result lost while the output register was full");

    a_yuv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.out_format == tmtf_pkg::FMT_YUV
            && out_data.out_size == tmtf_pkg::SIZE_16) |-> (out_data.texel_bits == 32'd0))
        else $error("yuv result carries nonzero texel bits");

endmodule

`default_nettype wire

// File: design/tmtf_out_buf.sv
// Output register stage for the texel fetch results.
// Depends on tmtf_pkg for the result beat type.
`default_nettype none

module tmtf_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    input  wire tmtf_pkg::out_t push_data,
    output logic               push_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tmtf_pkg::out_t     out_data
);

    logic           valid_reg;
    tmtf_pkg::out_t data_reg;

    assign push_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire
